/* hdl/hex_color_string_parser_unit_macros.svh */
// Assertion macros shared by the hex color string parser RTL.
`ifndef HEX_COLOR_STRING_PARSER_UNIT_MACROS_SVH
`define HEX_COLOR_STRING_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and off during reset.
`define HCSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcsp assertion failed");

// Next-cycle implication, checked on clk and off during reset.
`define HCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcsp assertion failed");

`endif

/* hdl/hcsp_pkg.sv */
// Types, constants and helper functions for the hex color string parser.
`timescale 1ns / 1ps
`default_nettype none
package hcsp_pkg;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [7:0]  CH_9     = 8'h39;
  localparam logic [7:0]  CH_UA    = 8'h41;
  localparam logic [7:0]  CH_UF    = 8'h46;
  localparam logic [7:0]  CH_LA    = 8'h61;
  localparam logic [7:0]  CH_LF_HEX = 8'h66;

  localparam logic [7:0]  LEN_RGB4  = 8'd4;
  localparam logic [7:0]  LEN_ARGB5 = 8'd5;
  localparam logic [7:0]  LEN_RGB7  = 8'd7;
  localparam logic [7:0]  LEN_ARGB9 = 8'd9;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_HEX   = 2'd1,
    PH_TRAIL = 2'd2,
    PH_FAIL  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] declared_length;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] argb;
  } out_beat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

  // Bit 4 set means the character is a hex digit; bits 3..0 give its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF_HEX) begin
      d = c - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] twin(input logic [3:0] n);
    return {n, n};
  endfunction

  function automatic logic [31:0] expand(input logic [31:0] v, input logic [7:0] len);
    logic [31:0] r;
    unique case (len)
      LEN_RGB4:  r = {8'hFF, twin(v[11:8]), twin(v[7:4]), twin(v[3:0])};
      LEN_ARGB5: r = {twin(v[15:12]), twin(v[11:8]), twin(v[7:4]), twin(v[3:0])};
      LEN_RGB7:  r = v | ALPHA_OPAQUE;
      LEN_ARGB9: r = v;
      default:   r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/hex_color_string_parser_unit.sv */
// Top level of the hex color string parser: input stage, parse state, result stage.
//
//   channel | dir | payload    | meaning
//   in_     | in  | in_beat_t  | one character, length used on terminator
//   out_    | out | out_beat_t | ok flag and packed ARGB, one per string
//
// One beat per cycle sustained while in_stall is low; a character is registered,
// then parsed in the next cycle against the phase/accumulator registers.
// A terminator leaving the input stage loads the result and sets out_valid.
// Reset (rst_n low, synchronous) empties both stages and returns to leading space.
// in_stall rises only when a terminator sits in the input stage and the
// result register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "hex_color_string_parser_unit_macros.svh"
module hex_color_string_parser_unit
  import hcsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  logic        s1_valid_r;
  in_beat_t    s1_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_r, out_nxt;

  logic        term;
  logic        out_free;
  logic        s1_adv;
  logic [4:0]  hv;

  assign term     = (s1_r.ch == CH_NUL);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!term || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign hv       = hex_value(s1_r.ch);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    if (s1_adv) begin
      if (term) begin
        phase_nxt = PH_LEAD;
        accum_nxt = 32'd0;
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            if (s1_r.ch == CH_HASH) begin
              phase_nxt = PH_HEX;
              accum_nxt = 32'd0;
            end else if (!is_space(s1_r.ch)) begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_HEX: begin
            if (hv[4]) begin
              accum_nxt = {accum_r[27:0], hv[3:0]};
            end else if (is_space(s1_r.ch)) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_TRAIL: begin
            if (!is_space(s1_r.ch)) begin
              phase_nxt = PH_FAIL;
            end
          end
          default: phase_nxt = PH_FAIL;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (s1_adv && term) begin
      out_valid_nxt = 1'b1;
      out_nxt.ok    = (phase_r == PH_HEX) || (phase_r == PH_TRAIL);
      out_nxt.argb  = out_nxt.ok ? expand(accum_r, s1_r.declared_length) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_LEAD;
      accum_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HCSP_ASSERT_NOW(a_char_never_stalls, s1_valid_r && !term, !in_stall)
  `HCSP_ASSERT_NOW(a_fail_gives_zero, out_valid_r && !out_r.ok, out_r.argb == 32'd0)
  `HCSP_ASSERT_NEXT(a_term_clears_state, s1_adv && term,
                    phase_r == PH_LEAD && accum_r == 32'd0)
  `HCSP_ASSERT_NEXT(a_term_makes_result, s1_adv && term, out_valid_r)

endmodule
`default_nettype wire
